// ===== hdl/lxh_pkg.sv =====
// Shared types, lexer tables and helper functions for the lexer token hash core.
// No dependencies; every other file in hdl/ imports this package.
`timescale 1ns / 1ps
package lxh_pkg;

  localparam int NSTATES = 63;
  localparam int STW = 6;
  localparam logic [63:0] HASH_MULT = 64'd13493690561280548289;
  localparam logic [31:0] MULT_LO = HASH_MULT[31:0];
  localparam logic [31:0] MULT_HI = HASH_MULT[63:32];
  localparam logic [63:0] DEC_MASK = 64'h8000;
  localparam logic [63:0] HEX_MASK = 64'h4000;

  localparam logic [STW-1:0] ST_START = 6'd0;
  localparam logic [STW-1:0] ST_WS = 6'd1;
  localparam logic [STW-1:0] ST_DEC = 6'd26;
  localparam logic [STW-1:0] ST_HEX = 6'd43;

  // symbol classes
  localparam logic [7:0] C_WS = 8'hF0;
  localparam logic [7:0] C_LET = 8'hF1;
  localparam logic [7:0] C_DIG = 8'hF2;
  localparam logic [7:0] C_ALN = 8'hF3;
  localparam logic [7:0] C_HEX = 8'hF4;
  localparam logic [7:0] C_NNL = 8'hF5;

  // token kinds; anything above K_HEX is a fixed code
  localparam int K_ERR = -1;
  localparam int K_NONE = 0;
  localparam int K_IDENT = 1;
  localparam int K_DEC = 2;
  localparam int K_HEX = 3;

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  // symbol that leads into each state
  localparam logic [7:0] SYM_OF [NSTATES] = '{
    8'h00, C_WS, 8'h65, 8'h61, 8'h6f, 8'h69, 8'h72, 8'h74, 8'h77, 8'h64, 8'h76, 8'h6e,
    8'h3a, 8'h3b, 8'h28, 8'h29, 8'h2c, 8'h3c, 8'h23, 8'h5b, 8'h5d, 8'h2d, 8'h2b, 8'h2a,
    8'h24, C_LET, C_DIG,
    8'h6e, 8'h6c, 8'h72, 8'h72, 8'h66, 8'h66, 8'h6e, 8'h65, 8'h68, 8'h68, 8'h6f, 8'h61,
    8'h6f, 8'h3d, 8'h2d, C_ALN, C_HEX,
    8'h64, 8'h73, 8'h72, 8'h74, 8'h74, 8'h65, 8'h69, 8'h72, 8'h74, C_NNL,
    8'h65, 8'h61, 8'h75, 8'h6e, 8'h6c, 8'h79, 8'h72, 8'h65, 8'h6e
  };

  // successor candidates in priority order, zero ends the list
  localparam logic [STW-1:0] SUCC [NSTATES][3] = '{
    '{6'd0, 6'd0, 6'd0}, '{6'd1, 6'd0, 6'd0}, '{6'd27, 6'd28, 6'd42},
    '{6'd29, 6'd42, 6'd0}, '{6'd30, 6'd31, 6'd42}, '{6'd32, 6'd33, 6'd42},
    '{6'd34, 6'd42, 6'd0}, '{6'd35, 6'd42, 6'd0}, '{6'd36, 6'd42, 6'd0},
    '{6'd37, 6'd42, 6'd0}, '{6'd38, 6'd42, 6'd0}, '{6'd39, 6'd42, 6'd0},
    '{6'd40, 6'd0, 6'd0},
    '{6'd0, 6'd0, 6'd0}, '{6'd0, 6'd0, 6'd0}, '{6'd0, 6'd0, 6'd0}, '{6'd0, 6'd0, 6'd0},
    '{6'd0, 6'd0, 6'd0}, '{6'd0, 6'd0, 6'd0}, '{6'd0, 6'd0, 6'd0}, '{6'd0, 6'd0, 6'd0},
    '{6'd41, 6'd0, 6'd0}, '{6'd0, 6'd0, 6'd0}, '{6'd0, 6'd0, 6'd0},
    '{6'd43, 6'd0, 6'd0}, '{6'd42, 6'd0, 6'd0}, '{6'd26, 6'd0, 6'd0},
    '{6'd44, 6'd42, 6'd0}, '{6'd45, 6'd42, 6'd0}, '{6'd46, 6'd42, 6'd0},
    '{6'd42, 6'd0, 6'd0}, '{6'd42, 6'd0, 6'd0}, '{6'd42, 6'd0, 6'd0},
    '{6'd47, 6'd42, 6'd0}, '{6'd48, 6'd42, 6'd0}, '{6'd49, 6'd42, 6'd0},
    '{6'd50, 6'd42, 6'd0}, '{6'd42, 6'd0, 6'd0}, '{6'd51, 6'd42, 6'd0},
    '{6'd52, 6'd42, 6'd0}, '{6'd0, 6'd0, 6'd0}, '{6'd53, 6'd0, 6'd0},
    '{6'd42, 6'd0, 6'd0}, '{6'd43, 6'd0, 6'd0},
    '{6'd42, 6'd0, 6'd0}, '{6'd54, 6'd42, 6'd0}, '{6'd55, 6'd42, 6'd0},
    '{6'd42, 6'd0, 6'd0}, '{6'd56, 6'd42, 6'd0}, '{6'd57, 6'd42, 6'd0},
    '{6'd58, 6'd42, 6'd0}, '{6'd42, 6'd0, 6'd0}, '{6'd42, 6'd0, 6'd0},
    '{6'd53, 6'd0, 6'd0},
    '{6'd42, 6'd0, 6'd0}, '{6'd59, 6'd42, 6'd0}, '{6'd60, 6'd42, 6'd0},
    '{6'd42, 6'd0, 6'd0}, '{6'd61, 6'd42, 6'd0},
    '{6'd42, 6'd0, 6'd0}, '{6'd62, 6'd42, 6'd0}, '{6'd42, 6'd0, 6'd0},
    '{6'd42, 6'd0, 6'd0}
  };

  // token kind of each final state
  localparam int KIND_OF [NSTATES] = '{
    K_ERR, K_NONE, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
    58, 59, 40, 41, 44, 60, 35, 91, 93, 45, 43, 42, K_ERR, 1, K_DEC,
    1, 1, 1, 268, 258, 261, 1, 1, 1, 1, 265, 1, 1, 269, K_NONE, 1, K_HEX,
    256, 1, 1, 259, 1, 1, 1, 266, 267, K_NONE,
    263, 1, 1, 262, 1,
    257, 1, 264,
    260
  };

  // one entry of the token queue
  typedef struct packed {
    logic fold;
    logic last;
    logic err;
    logic [31:0] val;
  } tok_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic sym_match(input logic [7:0] s, input logic [7:0] c);
    logic r;
    case (s)
      C_WS: r = (c == 8'h20) || (c == 8'h09) || (c == 8'h0a);
      C_LET: r = is_letter(c);
      C_DIG: r = is_digit(c);
      C_ALN: r = is_letter(c) || is_digit(c);
      C_HEX: r = is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
      C_NNL: r = (c != 8'h0a);
      default: r = (c == s);
    endcase
    return r;
  endfunction

  // successor of state st on byte c, zero when there is none
  function automatic logic [STW-1:0] dfa_next(input logic [STW-1:0] st, input logic [7:0] c);
    logic [STW-1:0] r;
    logic [STW-1:0] t;
    r = ST_START;
    if (st == ST_START || int'(st) >= NSTATES) begin
      if (sym_match(SYM_OF[1], c)) r = ST_WS;
      for (int i = 26; i >= 2; i--) begin
        if (sym_match(SYM_OF[i], c)) r = STW'(i);
      end
    end else begin
      for (int k = 2; k >= 0; k--) begin
        t = SUCC[st][k];
        if (t != ST_START && sym_match(SYM_OF[t], c)) r = t;
      end
    end
    return r;
  endfunction

  function automatic int kind_of(input logic [STW-1:0] st);
    return (int'(st) < NSTATES) ? KIND_OF[st] : K_ERR;
  endfunction

endpackage

// ===== hdl/lxh_front.sv =====
// Front end: steps the lexer automaton one byte per cycle while take is high,
// builds the open token and pushes finished token values and end markers. Depends on lxh_pkg.
`timescale 1ns / 1ps
module lxh_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        char_byte,
  input  logic              end_of_input,
  output logic              push,
  output lxh_pkg::tok_t     push_tok
);
  import lxh_pkg::*;

  logic [STW-1:0] st;
  logic           active;
  logic [31:0]    ident_hash;
  logic [63:0]    number_value;
  logic           number_overflow;
  logic           error_seen;

  logic [STW-1:0] nxt, restart, st_next;
  logic           brk;
  int             kind;
  logic [63:0]    num_sat;
  logic [31:0]    tok_val;
  logic           tok_fold, tok_err;
  logic [31:0]    hash_base, hash_sum;
  logic [63:0]    hash_prod;
  logic [63:0]    num_base;
  logic [67:0]    dec_wide;
  logic [3:0]     digit;
  logic [63:0]    num_next;
  logic           ovf_base, ovf_next;

  always_comb begin
    nxt = dfa_next(st, char_byte);
    brk = (nxt == ST_START);
    restart = dfa_next(ST_START, char_byte);
    st_next = brk ? restart : nxt;

    kind = kind_of(st);
    num_sat = number_overflow ? '1 : number_value;
    tok_fold = active && (kind != K_ERR) && (kind != K_NONE);
    tok_err = active && (kind == K_ERR);
    if (kind == K_IDENT) tok_val = ident_hash;
    else if (kind == K_DEC) tok_val = num_sat[31:0] ^ DEC_MASK[31:0];
    else if (kind == K_HEX) tok_val = num_sat[31:0] ^ HEX_MASK[31:0];
    else tok_val = 32'(kind);

    // the new byte extends the open token or starts a fresh one
    hash_base = brk ? '0 : ident_hash;
    num_base = brk ? '0 : number_value;
    ovf_base = brk ? 1'b0 : number_overflow;
    hash_sum = hash_base + {24'd0, char_byte};
    hash_prod = hash_sum * MULT_LO;

    if (is_digit(char_byte)) digit = 4'(char_byte - 8'h30);
    else if (char_byte >= 8'h61) digit = 4'(char_byte - 8'h57);
    else digit = 4'(char_byte - 8'h37);
    dec_wide = {1'b0, num_base, 3'b000} + {3'b000, num_base, 1'b0} + {64'd0, digit};

    num_next = num_base;
    ovf_next = ovf_base;
    if (st_next == ST_DEC) begin
      num_next = dec_wide[63:0];
      ovf_next = ovf_base || (dec_wide[67:64] != 4'd0);
    end else if (st_next == ST_HEX) begin
      num_next = {num_base[59:0], digit};
      ovf_next = ovf_base || (num_base[63:60] != 4'd0);
    end
  end

  always_comb begin
    push = take && (end_of_input || (brk && tok_fold));
    push_tok.fold = tok_fold;
    push_tok.last = end_of_input;
    push_tok.err = end_of_input && (error_seen || tok_err);
    push_tok.val = tok_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_START;
      active <= 1'b0;
      ident_hash <= '0;
      number_value <= '0;
      number_overflow <= 1'b0;
      error_seen <= 1'b0;
    end else if (take) begin
      if (end_of_input) begin
        st <= ST_START;
        active <= 1'b0;
        ident_hash <= '0;
        number_value <= '0;
        number_overflow <= 1'b0;
        error_seen <= 1'b0;
      end else if (st_next == ST_START) begin
        // byte not accepted from start: drop it
        error_seen <= 1'b1;
        st <= ST_START;
        active <= 1'b0;
        ident_hash <= '0;
        number_value <= '0;
        number_overflow <= 1'b0;
      end else begin
        if (brk && tok_err) error_seen <= 1'b1;
        st <= st_next;
        active <= 1'b1;
        ident_hash <= hash_prod[31:0];
        number_value <= num_next;
        number_overflow <= ovf_next;
      end
    end
  end

endmodule

// ===== hdl/lxh_queue.sv =====
// Small token queue between the lexer front end and the hash back end.
// Depends on lxh_pkg.
`timescale 1ns / 1ps
module lxh_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  lxh_pkg::tok_t din,
  output logic          full,
  input  logic          rd_en,
  output lxh_pkg::tok_t dout,
  output logic          empty
);
  import lxh_pkg::*;

  tok_t           mem [QDEPTH];
  logic [QAW-1:0] wp, rp;
  logic [QAW:0]   count;

  assign full = (count == (QAW+1)'(QDEPTH));
  assign empty = (count == '0);
  assign dout = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (wr_en) wp <= wp + 1'b1;
      if (rd_en) rp <= rp + 1'b1;
      if (wr_en && !rd_en) count <= count + 1'b1;
      else if (rd_en && !wr_en) count <= count - 1'b1;
    end
  end

endmodule

// ===== hdl/lxh_back.sv =====
// Back end: folds token values into the 64-bit running hash with one shared
// 32x32 multiplier over states PH_MUL0-PH_MUL2 and emits the result word. Depends on lxh_pkg.
`timescale 1ns / 1ps
module lxh_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  lxh_pkg::tok_t q_tok,
  output logic          q_pop,
  output logic          busy,
  output logic          emitting,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [63:0]   token_hash,
  output logic          lexical_error
);
  import lxh_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_MUL0 = 3'd1;
  localparam logic [2:0] PH_MUL1 = 3'd2;
  localparam logic [2:0] PH_MUL2 = 3'd3;
  localparam logic [2:0] PH_EMIT = 3'd4;

  logic [2:0]  phase;
  logic [63:0] total;
  logic [63:0] sum;
  logic [63:0] acc;
  logic        last;
  logic        err;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic        load_out;

  assign q_pop = (phase == PH_IDLE) && !q_empty;
  assign busy = (phase != PH_IDLE);
  assign emitting = (phase == PH_EMIT);
  assign load_out = (phase == PH_EMIT) && (!out_valid || out_ready);

  always_comb begin
    case (phase)
      PH_MUL1: begin
        mul_a = sum[31:0];
        mul_b = MULT_HI;
      end
      PH_MUL2: begin
        mul_a = sum[63:32];
        mul_b = MULT_LO;
      end
      default: begin
        mul_a = sum[31:0];
        mul_b = MULT_LO;
      end
    endcase
    prod = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      total <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (phase)
        PH_IDLE: begin
          if (!q_empty) begin
            last <= q_tok.last;
            err <= q_tok.err;
            sum <= total + {{32{q_tok.val[31]}}, q_tok.val};
            phase <= q_tok.fold ? PH_MUL0 : PH_EMIT;
          end
        end
        PH_MUL0: begin
          acc <= prod;
          phase <= PH_MUL1;
        end
        PH_MUL1: begin
          acc[63:32] <= acc[63:32] + prod[31:0];
          phase <= PH_MUL2;
        end
        PH_MUL2: begin
          total <= {acc[63:32] + prod[31:0], acc[31:0]};
          phase <= last ? PH_EMIT : PH_IDLE;
        end
        PH_EMIT: begin
          if (load_out) begin
            token_hash <= total;
            lexical_error <= err;
            total <= '0;
            phase <= PH_IDLE;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/lexer_dfa_token_hash_core.sv =====
// Top level of the lexer token hash core: front end, token queue, back end.
// Depends on lxh_pkg, lxh_front, lxh_queue and lxh_back.
`timescale 1ns / 1ps
//
//  channel  | handshake           | word
//  ---------+---------------------+---------------------------------
//  input    | in_valid / in_ready | char_byte, end_of_input
//  output   | out_valid/out_ready | token_hash, lexical_error
//
// The front end takes one byte every cycle while the token queue has room.
// Each finished token takes the back end through an add, then three steps of the
// shared 32x32 multiplier, and the back end pops no new token until it is idle
// again, so input stalls on a run of one-byte tokens once the four-entry queue has filled.
// An end marker's word is loaded into the output register from PH_EMIT, which follows
// its last multiplier step (or its pop when nothing is folded), later if the output
// register still holds an unread word. Reset clears the lexer state, queue and total.
module lexer_dfa_token_hash_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_byte,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] token_hash,
  output logic        lexical_error
);
  import lxh_pkg::*;

  logic take;
  logic q_push, q_full, q_pop, q_empty;
  tok_t push_tok, q_tok;
  logic back_busy, back_emitting;

  // accept a byte whenever the queue can hold whatever it produces
  assign in_ready = !q_full;
  assign take = in_valid && in_ready;

  lxh_front u_front (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .char_byte    (char_byte),
    .end_of_input (end_of_input),
    .push         (q_push),
    .push_tok     (push_tok)
  );

  lxh_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr_en (q_push),
    .din   (push_tok),
    .full  (q_full),
    .rd_en (q_pop),
    .dout  (q_tok),
    .empty (q_empty)
  );

  lxh_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_tok         (q_tok),
    .q_pop         (q_pop),
    .busy          (back_busy),
    .emitting      (back_emitting),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .token_hash    (token_hash),
    .lexical_error (lexical_error)
  );

  // never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(q_push && q_full))
    else $error("token queue overflow");

  // the back end pops only between tokens
  a_pop_idle: assert property (@(posedge clk) disable iff (rst) !(q_pop && back_busy))
    else $error("queue pop while back end busy");

  // a new result only appears out of the emit step
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(back_emitting))
    else $error("result raised outside emit step");

endmodule
